[hdl/sss_pkg.sv]
package sss_pkg;

    localparam int AREA_W = 50;
    localparam int PROB_W = 17;
    localparam int COST_W = 40;
    localparam int CNT_W  = 13;
    localparam int EDGE_W = 14;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_AXIS_MIN      = 3'd0,
        REG_AXIS_MAX      = 3'd1,
        REG_CROSS_ONE     = 3'd2,
        REG_CROSS_TWO     = 3'd3,
        REG_STEP_COST     = 3'd4,
        REG_HIT_COST      = 3'd5,
        REG_EMPTY_DISC    = 3'd6,
        REG_PRIM_TOTAL    = 3'd7
    } cfg_reg_t;

    // Operations of the shared multiplier; the tag travels with the product.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_E1E2,
        MUL_LEN_E1,
        MUL_LEN_E2,
        MUL_PROB_B,
        MUL_PROB_A,
        MUL_PB_BELOW,
        MUL_PA_ABOVE,
        MUL_HD,
        MUL_WHD,
        MUL_INIT
    } mul_op_t;

    // Length that enters a half-area product.
    typedef enum logic [1:0] {
        LEN_DX,
        LEN_TB,
        LEN_TA
    } len_sel_t;

    typedef struct packed {
        mul_op_t  mul;
        len_sel_t len;
        logic     node_init;
        logic     norm_load;
        logic     norm_step;
        logic     inv_zero;
        logic     div_load;
        logic     div_step;
        logic     inv_load;
        logic     item_load;
        logic     item_update;
        logic     cost_cmp;
        logic     close_fin;
        logic     emit;
    } sss_cmd_t;

    typedef struct packed {
        logic counter_zero;
        logic need_close;
        logic price_ok;
        logic last;
        logic tn_zero;
        logic norm_ok;
        logic out_free;
    } sss_status_t;

endpackage

[hdl/sss_ctrl.sv]
module sss_ctrl
    import sss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sss_status_t status,
    output sss_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_N_E1E2, ST_N_LE1, ST_N_LE2, ST_N_INIT, ST_N_LOAD,
        ST_NORM, ST_DIV, ST_DIV_END, ST_CHECK, ST_C_TEST,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_P10, ST_P11, ST_P12, ST_P13, ST_CMP, ST_FIN, ST_UPDATE, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       post_reg, post_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        post_next  = post_reg;
        cmd        = '0;
        cmd.mul    = MUL_NONE;
        cmd.len    = LEN_DX;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next = status.counter_zero ? ST_N_E1E2 : ST_CHECK;
                end
            end
            ST_N_E1E2: begin
                cmd.mul = MUL_E1E2;
                state_next = ST_N_LE1;
            end
            ST_N_LE1: begin
                cmd.mul = MUL_LEN_E1;
                state_next = ST_N_LE2;
            end
            ST_N_LE2: begin
                cmd.mul = MUL_LEN_E2;
                state_next = ST_N_INIT;
            end
            ST_N_INIT: begin
                cmd.mul = MUL_INIT;
                state_next = ST_N_LOAD;
            end
            ST_N_LOAD: begin
                cmd.node_init = 1'b1;
                cmd.norm_load = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (status.tn_zero) begin
                    cmd.inv_zero = 1'b1;
                    state_next = ST_CHECK;
                end else if (status.norm_ok) begin
                    cmd.div_load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_DIV;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                cmd.inv_load = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                post_next = 1'b0;
                state_next = status.need_close ? ST_C_TEST : ST_UPDATE;
            end
            ST_C_TEST: begin
                state_next = status.price_ok ? ST_P1 : ST_FIN;
            end
            ST_P1: begin
                cmd.mul = MUL_E1E2;
                state_next = ST_P2;
            end
            ST_P2: begin
                cmd.mul = MUL_LEN_E1;
                cmd.len = LEN_TB;
                state_next = ST_P3;
            end
            ST_P3: begin
                cmd.mul = MUL_LEN_E2;
                cmd.len = LEN_TB;
                state_next = ST_P4;
            end
            ST_P4: begin
                cmd.mul = MUL_LEN_E1;
                cmd.len = LEN_TA;
                state_next = ST_P5;
            end
            ST_P5: begin
                cmd.mul = MUL_PROB_B;
                state_next = ST_P6;
            end
            ST_P6: begin
                cmd.mul = MUL_LEN_E2;
                cmd.len = LEN_TA;
                state_next = ST_P7;
            end
            ST_P7: begin
                cmd.mul = MUL_PB_BELOW;
                state_next = ST_P8;
            end
            ST_P8: begin
                cmd.mul = MUL_PROB_A;
                state_next = ST_P9;
            end
            ST_P9: begin
                cmd.mul = MUL_HD;
                state_next = ST_P10;
            end
            ST_P10: begin
                cmd.mul = MUL_PA_ABOVE;
                state_next = ST_P11;
            end
            ST_P11: begin
                state_next = ST_P12;
            end
            ST_P12: begin
                cmd.mul = MUL_WHD;
                state_next = ST_P13;
            end
            ST_P13: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cost_cmp = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.close_fin = 1'b1;
                state_next = post_reg ? ST_EMIT : ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.item_update = 1'b1;
                if (status.last) begin
                    post_next = 1'b1;
                    state_next = ST_C_TEST;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            post_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            post_reg  <= post_next;
        end
    end

endmodule

[hdl/sss_datapath.sv]
module sss_datapath
    import sss_pkg::*;
#(
    parameter int MAX_PRIMS = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  s_edge_position,
    input  logic                s_edge_is_end,
    input  logic                s_last_edge,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_split_found,
    output logic [CNT_W-1:0]    m_split_edge_index,
    output logic [COST_W-1:0]   m_split_cost,
    input  sss_cmd_t            cmd,
    output sss_status_t         status
);

    localparam int unsigned PRIM_CAP = (MAX_PRIMS > 8191) ? 8191 : MAX_PRIMS;
    localparam logic [CNT_W-1:0] PRIM_CAP_C = PRIM_CAP[CNT_W-1:0];
    localparam logic [AREA_W-1:0] AREA_LIM = {18'd0, 32'hFFFF_FFFF};

    // Configuration registers.
    logic signed [31:0] axis_min_reg, axis_max_reg;
    logic [31:0]        ext1_reg, ext2_reg;
    logic [15:0]        step_cost_reg, hit_cost_reg;
    logic [7:0]         discount_reg;
    logic [CNT_W-1:0]   prim_total_reg;

    // Current item.
    logic signed [31:0] pos_reg;
    logic               is_end_reg, last_reg;

    // Sweep state.
    logic [EDGE_W-1:0]  edge_counter_reg;
    logic [CNT_W-1:0]   below_reg, above_reg, tally_reg, cand_reg, best_index_reg;
    logic signed [31:0] group_pos_reg;
    logic               group_open_reg, group_seen_reg, best_valid_reg;
    logic [COST_W-1:0]  best_cost_reg;
    logic [31:0]        inv_reg;
    logic [5:0]         shift_reg;
    logic               left_reg;

    // Arithmetic work registers.
    logic [63:0]        prod_reg;
    mul_op_t            tag_reg;
    logic [47:0]        e1e2_reg;
    logic [AREA_W-1:0]  area_reg, tn_reg;
    logic [PROB_W-1:0]  pb_reg, pa_reg;
    logic [31:0]        w_reg, quo_reg;
    logic [23:0]        hd_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [32:0]        rem_reg;

    // Output register.
    logic               m_valid_reg, found_reg;
    logic [CNT_W-1:0]   out_index_reg;
    logic [COST_W-1:0]  out_cost_reg;

    logic signed [32:0] lo_x, hi_x, t_x, dx_full, tb_full, ta_full;
    logic [31:0]        len, an, mul_a, mul_b;
    logic [AREA_W-1:0]  area_shl, area_shr, area_lim;
    logic [CNT_W-1:0]   prim_n, idx;
    logic [7:0]         disc_eff;
    logic [8:0]         hd_factor;
    logic [COST_W:0]    cost_sum;
    logic [CNT_W:0]     below_sum;
    logic [32:0]        rem_shift, tn_div;
    logic               seen_cur;
    logic [CNT_W-1:0]   tally_cur;

    assign lo_x    = {axis_min_reg[31], axis_min_reg};
    assign hi_x    = {axis_max_reg[31], axis_max_reg};
    assign t_x     = {group_pos_reg[31], group_pos_reg};
    assign dx_full = hi_x - lo_x;
    assign tb_full = t_x - lo_x;
    assign ta_full = hi_x - t_x;

    always_comb begin
        case (cmd.len)
            LEN_TB:  len = tb_full[31:0];
            LEN_TA:  len = ta_full[31:0];
            default: len = (hi_x > lo_x) ? dx_full[31:0] : 32'd0;
        endcase
    end

    // Bring an area into the scale of the normalized node total.
    assign area_shl = area_reg << shift_reg;
    assign area_shr = area_reg >> shift_reg;
    assign area_lim = AREA_LIM >> shift_reg;

    always_comb begin
        if (left_reg) begin
            an = (area_reg > area_lim) ? 32'hFFFF_FFFF : area_shl[31:0];
        end else begin
            an = (area_shr > AREA_LIM) ? 32'hFFFF_FFFF : area_shr[31:0];
        end
    end

    assign prim_n    = (prim_total_reg < PRIM_CAP_C) ? prim_total_reg : PRIM_CAP_C;
    assign disc_eff  = (below_reg == '0 || above_reg == '0) ? discount_reg : 8'd0;
    assign hd_factor = 9'd256 - {1'b0, disc_eff};

    always_comb begin
        case (cmd.mul)
            MUL_E1E2: begin
                mul_a = ext1_reg;
                mul_b = ext2_reg;
            end
            MUL_LEN_E1: begin
                mul_a = len;
                mul_b = ext1_reg;
            end
            MUL_LEN_E2: begin
                mul_a = len;
                mul_b = ext2_reg;
            end
            MUL_PROB_B, MUL_PROB_A: begin
                mul_a = an;
                mul_b = inv_reg;
            end
            MUL_PB_BELOW: begin
                mul_a = {15'd0, pb_reg};
                mul_b = {19'd0, below_reg};
            end
            MUL_PA_ABOVE: begin
                mul_a = {15'd0, pa_reg};
                mul_b = {19'd0, above_reg};
            end
            MUL_HD: begin
                mul_a = {16'd0, hit_cost_reg};
                mul_b = {23'd0, hd_factor};
            end
            MUL_WHD: begin
                mul_a = w_reg;
                mul_b = {8'd0, hd_reg};
            end
            MUL_INIT: begin
                mul_a = {16'd0, hit_cost_reg};
                mul_b = {19'd0, prim_n};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign cost_sum  = {1'b0, prod_reg[55:16]} + {17'd0, step_cost_reg, 8'd0};
    assign below_sum = {1'b0, below_reg} + {1'b0, tally_reg};
    assign rem_shift = {rem_reg[31:0], 1'b1};
    assign tn_div    = {1'b0, tn_reg[31:0]};
    assign seen_cur  = group_open_reg & group_seen_reg;
    assign tally_cur = group_open_reg ? tally_reg : '0;
    assign idx       = edge_counter_reg[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_min_reg   <= '0;
            axis_max_reg   <= '0;
            ext1_reg       <= '0;
            ext2_reg       <= '0;
            step_cost_reg  <= 16'd256;
            hit_cost_reg   <= 16'd256;
            discount_reg   <= '0;
            prim_total_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AXIS_MIN:   axis_min_reg   <= cfg_data;
                REG_AXIS_MAX:   axis_max_reg   <= cfg_data;
                REG_CROSS_ONE:  ext1_reg       <= cfg_data;
                REG_CROSS_TWO:  ext2_reg       <= cfg_data;
                REG_STEP_COST:  step_cost_reg  <= cfg_data[15:0];
                REG_HIT_COST:   hit_cost_reg   <= cfg_data[15:0];
                REG_EMPTY_DISC: discount_reg   <= cfg_data[7:0];
                REG_PRIM_TOTAL: prim_total_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // Shared multiplier with its result tag; the product and its tag are registered
    // together, then the product is retired into the register that the tag names.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            tag_reg <= MUL_NONE;
        end else begin
            tag_reg <= cmd.mul;
        end
    end

    always_ff @(posedge aclk) begin
        case (tag_reg)
            MUL_E1E2:     e1e2_reg <= prod_reg[63:16];
            MUL_LEN_E1:   area_reg <= {2'd0, e1e2_reg} + {2'd0, prod_reg[63:16]};
            MUL_LEN_E2:   area_reg <= area_reg + {2'd0, prod_reg[63:16]};
            MUL_PROB_B:   pb_reg   <= prod_reg[63:47];
            MUL_PROB_A:   pa_reg   <= prod_reg[63:47];
            MUL_PB_BELOW: w_reg    <= prod_reg[31:0];
            MUL_PA_ABOVE: w_reg    <= w_reg + prod_reg[31:0];
            MUL_HD:       hd_reg   <= prod_reg[23:0];
            MUL_WHD:      cost_reg <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
            default: ;
        endcase

        if (cmd.item_load) begin
            pos_reg    <= s_edge_position;
            is_end_reg <= s_edge_is_end;
            last_reg   <= s_last_edge;
        end

        if (cmd.norm_load) begin
            tn_reg    <= area_reg;
            shift_reg <= '0;
            left_reg  <= 1'b0;
        end else if (cmd.norm_step) begin
            shift_reg <= shift_reg + 6'd1;
            if (tn_reg[AREA_W-1:32] != '0) begin
                tn_reg   <= tn_reg >> 1;
                left_reg <= 1'b0;
            end else begin
                tn_reg   <= tn_reg << 1;
                left_reg <= 1'b1;
            end
        end else if (cmd.inv_zero) begin
            shift_reg <= '0;
            left_reg  <= 1'b0;
        end

        // Restoring division of 2^63 - 1 by the normalized total.
        if (cmd.div_load) begin
            rem_reg <= 33'h0_7FFF_FFFF;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_shift >= tn_div) begin
                rem_reg <= rem_shift - tn_div;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end

        if (cmd.inv_load) begin
            inv_reg <= quo_reg;
        end else if (cmd.inv_zero) begin
            inv_reg <= '0;
        end
    end

    // Sweep state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_counter_reg <= '0;
            group_open_reg   <= 1'b0;
            best_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (tag_reg == MUL_INIT) begin
                best_cost_reg <= {3'd0, prod_reg[28:0], 8'd0};
            end

            if (cmd.node_init) begin
                below_reg      <= '0;
                above_reg      <= prim_n;
                best_valid_reg <= 1'b0;
                best_index_reg <= '0;
                group_open_reg <= 1'b0;
            end

            if (cmd.cost_cmp && cost_reg < best_cost_reg) begin
                best_cost_reg  <= cost_reg;
                best_index_reg <= cand_reg;
                best_valid_reg <= 1'b1;
            end

            if (cmd.close_fin) begin
                below_reg      <= below_sum[CNT_W] ? '1 : below_sum[CNT_W-1:0];
                group_open_reg <= 1'b0;
            end

            if (cmd.item_update) begin
                group_open_reg   <= 1'b1;
                group_pos_reg    <= pos_reg;
                edge_counter_reg <= edge_counter_reg + 1'b1;
                if (!seen_cur && is_end_reg) begin
                    if (above_reg != '0) begin
                        above_reg <= above_reg - 1'b1;
                    end
                    cand_reg       <= idx;
                    group_seen_reg <= 1'b0;
                    tally_reg      <= tally_cur;
                end else begin
                    if (!seen_cur) begin
                        cand_reg <= idx;
                    end
                    group_seen_reg <= 1'b1;
                    tally_reg      <= (tally_cur != '1) ? tally_cur + 1'b1 : tally_cur;
                end
            end

            if (cmd.emit) begin
                m_valid_reg      <= 1'b1;
                found_reg        <= best_valid_reg;
                out_index_reg    <= best_valid_reg ? best_index_reg : '0;
                out_cost_reg     <= best_cost_reg;
                edge_counter_reg <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_split_found      = found_reg;
    assign m_split_edge_index = out_index_reg;
    assign m_split_cost       = out_cost_reg;

    assign status.counter_zero = (edge_counter_reg == '0);
    assign status.need_close   = group_open_reg && (pos_reg != group_pos_reg);
    assign status.price_ok     = (t_x > lo_x) && (t_x < hi_x) && (inv_reg != '0);
    assign status.last         = last_reg;
    assign status.tn_zero      = (tn_reg == '0);
    assign status.norm_ok      = (tn_reg[AREA_W-1:32] == '0) && tn_reg[31];
    assign status.out_free     = !m_valid_reg || m_ready;

    // The divider only starts on a total that sits in [2^31, 2^32).
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> (tn_reg[AREA_W-1:32] == '0) && tn_reg[31])
        else $error("divider started on an unnormalized total");

    // A normalized divisor always gives a quotient of at least 2^31.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.inv_load |-> quo_reg[31])
        else $error("inverse area out of range");

    // A result is never written over one still waiting downstream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

endmodule

[hdl/sah_split_sweep_core.sv]
// Channel    Direction  Handshake            Payload
// s_         in         s_valid / s_ready    edge_position, edge_is_end, last_edge
// m_         out        m_valid / m_ready    split_found, split_edge_index, split_cost
// cfg_       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item that does not close a group goes through the check and update states;
// one that closes a group adds the close test and finish, plus the cost steps
// when the position lies inside the node, since every product of the cost goes
// through one shared 32 x 32 multiplier. A node's first item adds the setup
// products, normalizing and a restoring division for the inverse node area (none
// for zero area). A last edge adds one more close and the result register load.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result waits in the output register while the next item is taken.
module sah_split_sweep_core
    import sss_pkg::*;
#(
    parameter int MAX_PRIMS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_edge_position,
    input  logic               s_edge_is_end,
    input  logic               s_last_edge,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_split_found,
    output logic [CNT_W-1:0]   m_split_edge_index,
    output logic [COST_W-1:0]  m_split_cost
);

    // The controller sequences node setup, group closes and result delivery;
    // the datapath holds the sweep counts, the cost arithmetic and the divider.
    sss_cmd_t    cmd;
    sss_status_t status;

    sss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sss_datapath #(
        .MAX_PRIMS (MAX_PRIMS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_edge_position    (s_edge_position),
        .s_edge_is_end      (s_edge_is_end),
        .s_last_edge        (s_last_edge),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_split_found      (m_split_found),
        .m_split_edge_index (m_split_edge_index),
        .m_split_cost       (m_split_cost),
        .cmd                (cmd),
        .status             (status)
    );

endmodule
